### src/cic_pkg.sv
package cic_pkg;

   // function codes on the request channel
   localparam logic FUNC_ENCODE = 1'b0;
   localparam logic FUNC_DECODE = 1'b1;

   // width mode register codes (code 3 behaves as the 30-bit mode)
   localparam logic [1:0] MODE_15 = 2'd0;
   localparam logic [1:0] MODE_22 = 2'd1;
   localparam logic [1:0] MODE_30 = 2'd2;
   localparam logic [1:0] MODE_RESET = MODE_30;

   // result kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_VALUE = 2'd1;
   localparam logic [1:0] KIND_RANGE = 2'd2;

   // encoding limits and tags
   localparam logic [29:0] MAX_ONE_BYTE = 30'h0000_007F;
   localparam logic [29:0] MAX_TWO_BYTE = 30'h0000_3FFF;
   localparam logic [29:0] MAX_MODE_15  = 30'h0000_7FFF;
   localparam logic [29:0] MAX_MODE_22  = 30'h003F_FFFF;
   localparam logic [29:0] MAX_MODE_30  = 30'h3FFF_FFFF;
   localparam logic [7:0]  TAG_TWO_BYTE = 8'h80;
   localparam logic [7:0]  TAG_LONG     = 8'hC0;

   // default depth of the queue between front and back
   localparam int QUEUE_DEPTH_DEF = 4;

   // one queued job: kind, number of bytes after the first, and the payload.
   // Byte jobs are left aligned (first byte in bits 31:24); value jobs sit
   // in bits 29:0.
   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  extra;
      logic [31:0] data;
   } cic_entry_type;

endpackage

### src/cic_front.sv
module cic_front
   import cic_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   // request channel
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_func,
   input  logic [29:0]   req_value_in,
   input  logic [7:0]    req_in_byte,
   // mode register write
   input  logic          csr_valid,
   input  logic [1:0]    csr_data,
   // queue push side
   input  logic          q_full,
   output logic          q_push,
   output cic_entry_type q_entry
);

   logic [1:0]  mode_ff, mode_in;
   logic [1:0]  rem_ff, rem_in;
   logic [29:0] acc_ff, acc_in;
   logic [1:0]  mode;
   logic [29:0] max_val;
   logic [29:0] acc_shift;
   logic        accept;
   logic        has_result;
   cic_entry_type enc_entry;
   cic_entry_type dec_entry;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign mode      = (mode_ff == MODE_15 || mode_ff == MODE_22) ? mode_ff : MODE_30;

   // mode register
   always_comb begin
      mode_in = mode_ff;
      if (csr_valid) begin
         mode_in = csr_data;
      end
   end

   // encode classification: range check and byte layout
   always_comb begin
      unique case (mode)
         MODE_15: max_val = MAX_MODE_15;
         MODE_22: max_val = MAX_MODE_22;
         default: max_val = MAX_MODE_30;
      endcase
      enc_entry = '0;
      if (req_value_in > max_val) begin
         enc_entry.kind = KIND_RANGE;
      end else if (req_value_in <= MAX_ONE_BYTE) begin
         enc_entry.kind  = KIND_BYTE;
         enc_entry.extra = 2'd0;
         enc_entry.data  = {req_value_in[7:0], 24'h0};
      end else if (mode == MODE_15 || req_value_in <= MAX_TWO_BYTE) begin
         enc_entry.kind  = KIND_BYTE;
         enc_entry.extra = 2'd1;
         enc_entry.data  = {req_value_in[15:8] | TAG_TWO_BYTE, req_value_in[7:0], 16'h0};
      end else if (mode == MODE_22) begin
         enc_entry.kind  = KIND_BYTE;
         enc_entry.extra = 2'd2;
         enc_entry.data  = {req_value_in[23:16] | TAG_LONG, req_value_in[15:0], 8'h0};
      end else begin
         enc_entry.kind  = KIND_BYTE;
         enc_entry.extra = 2'd3;
         enc_entry.data  = {2'b11, req_value_in[29:0]};
      end
   end

   // decode: track bytes still missing and accumulate
   always_comb begin
      rem_in     = rem_ff;
      acc_in     = acc_ff;
      has_result = 1'b0;
      acc_shift  = {acc_ff[21:0], req_in_byte};
      dec_entry  = '0;
      dec_entry.kind = KIND_VALUE;
      if (rem_ff == 2'd0) begin
         if (!req_in_byte[7]) begin
            has_result     = 1'b1;
            dec_entry.data = {24'h0, req_in_byte};
         end else if (mode == MODE_15) begin
            acc_in = {23'h0, req_in_byte[6:0]};
            rem_in = 2'd1;
         end else begin
            acc_in = {24'h0, req_in_byte[5:0]};
            if (!req_in_byte[6]) begin
               rem_in = 2'd1;
            end else begin
               rem_in = (mode == MODE_22) ? 2'd2 : 2'd3;
            end
         end
      end else begin
         acc_in = acc_shift;
         rem_in = rem_ff - 2'd1;
         if (rem_ff == 2'd1) begin
            has_result     = 1'b1;
            dec_entry.data = {2'b00, acc_shift};
         end
      end
   end

   // queue push
   always_comb begin
      q_push  = 1'b0;
      q_entry = enc_entry;
      if (accept) begin
         if (req_func == FUNC_ENCODE) begin
            q_push = 1'b1;
         end else begin
            q_push  = has_result;
            q_entry = dec_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
         rem_ff  <= 2'd0;
      end else begin
         mode_ff <= mode_in;
         if (accept && req_func == FUNC_DECODE) begin
            rem_ff <= rem_in;
         end
      end
      if (accept && req_func == FUNC_DECODE) begin
         acc_ff <= acc_in;
      end
   end

endmodule

### src/cic_queue.sv
module cic_queue
   import cic_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cic_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          empty,
   output cic_entry_type head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cic_entry_type         store [DEPTH];
   logic [PTR_W-1:0]      wr_ff, wr_in;
   logic [PTR_W-1:0]      rd_ff, rd_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  do_push;
   logic                  do_pop;

   assign full    = (cnt_ff == FULL_CNT);
   assign empty   = (cnt_ff == '0);
   assign head    = store[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         store[wr_ff] <= push_entry;
      end
   end

endmodule

### src/cic_back.sv
module cic_back
   import cic_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   // queue pop side
   input  logic          q_empty,
   input  cic_entry_type q_head,
   output logic          q_pop,
   // response channel
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [1:0]    rsp_kind,
   output logic [7:0]    rsp_out_byte,
   output logic [29:0]   rsp_value_out,
   output logic          rsp_last
);

   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic [29:0] value_ff, value_in;
   logic        last_ff, last_in;
   logic [1:0]  hold_cnt_ff, hold_cnt_in;
   logic [31:0] hold_data_ff, hold_data_in;
   logic        load_ok;
   logic        from_hold;

   assign load_ok   = !valid_ff || rsp_ready;
   assign from_hold = (hold_cnt_ff != 2'd0);
   assign q_pop     = load_ok && !from_hold && !q_empty;

   // next output word: remaining bytes of the current job first, then the queue
   always_comb begin
      valid_in     = valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      byte_in      = byte_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      hold_cnt_in  = hold_cnt_ff;
      hold_data_in = hold_data_ff;
      if (load_ok && from_hold) begin
         valid_in     = 1'b1;
         kind_in      = KIND_BYTE;
         byte_in      = hold_data_ff[31:24];
         value_in     = '0;
         last_in      = (hold_cnt_ff == 2'd1);
         hold_cnt_in  = hold_cnt_ff - 2'd1;
         hold_data_in = {hold_data_ff[23:0], 8'h0};
      end else if (q_pop) begin
         valid_in = 1'b1;
         kind_in  = q_head.kind;
         unique case (q_head.kind)
            KIND_BYTE: begin
               byte_in      = q_head.data[31:24];
               value_in     = '0;
               last_in      = (q_head.extra == 2'd0);
               hold_cnt_in  = q_head.extra;
               hold_data_in = {q_head.data[23:0], 8'h0};
            end
            KIND_VALUE: begin
               byte_in  = '0;
               value_in = q_head.data[29:0];
               last_in  = 1'b1;
            end
            default: begin
               byte_in  = '0;
               value_in = '0;
               last_in  = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         hold_cnt_ff <= 2'd0;
      end else begin
         valid_ff    <= valid_in;
         hold_cnt_ff <= hold_cnt_in;
      end
      kind_ff      <= kind_in;
      byte_ff      <= byte_in;
      value_ff     <= value_in;
      last_ff      <= last_in;
      hold_data_ff <= hold_data_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_value_out = value_ff;
   assign rsp_last      = last_ff;

endmodule

### src/compressed_int_codec_top.sv
// Channel   Direction  Handshake             Word
// req_      in         req_valid/req_ready   func, value_in (30b), in_byte (8b)
// rsp_      out        rsp_valid/rsp_ready   kind, out_byte, value_out, last
// csr_      in         csr_valid/csr_ready   data: width mode (2b)
//
// One request word per cycle is taken while the queue has room; an encode
// emits 1 to 4 response words at one per cycle while rsp_ready is held, paced
// by the back end's byte sequencer, and later requests still enter the queue.
// A job is registered in the queue storage, then in the back end's response register.
// Synchronous active-high reset; width mode resets to the 30-bit form.
// Queue of QUEUE_DEPTH jobs decouples the sides; rsp stalls back up into it.
module compressed_int_codec_top
   import cic_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [29:0] req_value_in,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [29:0] rsp_value_out,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data
);

   logic          q_push;
   logic          q_full;
   logic          q_pop;
   logic          q_empty;
   cic_entry_type q_entry;
   cic_entry_type q_head;

   assign csr_ready = 1'b1;

   // accept and classify
   cic_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_value_in (req_value_in),
      .req_in_byte  (req_in_byte),
      .csr_valid    (csr_valid),
      .csr_data     (csr_data),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_entry      (q_entry)
   );

   // job queue
   cic_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   // byte sequencer and response register
   cic_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_value_out (rsp_value_out),
      .rsp_last      (rsp_last)
   );

endmodule

### src/cic_checker.sv
module cic_checker
   import cic_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_out_byte,
   input logic [29:0] rsp_value_out,
   input logic        rsp_last
);

   // response comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
         $stable(rsp_out_byte) && $stable(rsp_value_out) && $stable(rsp_last))
      else $error("stalled response word changed");

   // decoded values and range errors are single-word results
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_VALUE || rsp_kind == KIND_RANGE) |-> rsp_last)
      else $error("single-word result without last");

   // unused payload fields are zero
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_BYTE || rsp_out_byte == '0) &&
         (rsp_kind == KIND_VALUE || rsp_value_out == '0))
      else $error("unused response field not zero");

   // a byte following a non-last byte is another byte
   a_byte_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last ##1 rsp_valid |-> rsp_kind == KIND_BYTE)
      else $error("encoded byte run broken");

endmodule

bind compressed_int_codec_top cic_checker u_cic_checker (.*);
